### rtl/core/fau_pkg.sv
`timescale 1ns / 1ps

package fau_pkg;

	localparam int NEURONS  = 64;
	localparam int FEATURES = 1024;
	localparam int LANE_W   = $clog2(NEURONS);
	localparam int FEAT_W   = 10;
	localparam int WADDR_W  = FEAT_W + LANE_W;
	localparam int WGT_W    = 8;
	localparam int ACC_W    = 16;
	localparam int OP_W     = 3;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_WEIGHT    = 3'd0,
		OP_LOAD_BIAS      = 3'd1,
		OP_SET_ENTRY      = 3'd2,
		OP_START_BIAS     = 3'd3,
		OP_ADD_FEATURE    = 3'd4,
		OP_REMOVE_FEATURE = 3'd5,
		OP_READ_OUT       = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ROW_START,
		ROW_ADD,
		ROW_SUB,
		ROW_READ
	} row_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic [FEAT_W-1:0]       feature_index;
		logic [LANE_W-1:0]       neuron_index;
		logic signed [WGT_W-1:0] weight_value;
		logic signed [ACC_W-1:0] word_value;
	} cmd_word_t;

	typedef struct packed {
		logic [LANE_W-1:0]       lane_index;
		logic signed [ACC_W-1:0] accumulator_value;
		logic                    last_lane;
	} res_word_t;

	typedef struct packed {
		logic              valid;
		row_op_t           op;
		logic [LANE_W-1:0] lane;
		logic              last;
	} issue_t;

	typedef struct packed {
		logic               we_weight;
		logic               we_bias;
		logic               we_acc;
		logic [WADDR_W-1:0] weight_addr;
		logic [LANE_W-1:0]  lane;
		logic [WGT_W-1:0]   weight;
		logic [ACC_W-1:0]   word;
	} cmd_wr_t;

endpackage

### rtl/core/fau_cmd_if.sv
`timescale 1ns / 1ps

interface fau_cmd_if;
	import fau_pkg::*;

	logic      valid;
	logic      ready;
	cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/fau_res_if.sv
`timescale 1ns / 1ps

interface fau_res_if;
	import fau_pkg::*;

	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/fau_ram.sv
`timescale 1ns / 1ps

module fau_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fau_seq.sv
`timescale 1ns / 1ps

module fau_seq (
	input  logic             clk,
	input  logic             arst_n,
	fau_cmd_if.sink          cmd,
	input  logic             stall,
	input  logic             busy,
	output fau_pkg::issue_t  issue,
	output fau_pkg::cmd_wr_t wr,
	output logic [fau_pkg::WADDR_W-1:0] weight_raddr
);
	import fau_pkg::*;

	state_t            state_q, state_d;
	row_op_t           op_q, op_d;
	logic [FEAT_W-1:0] feature_q, feature_d;
	logic [LANE_W-1:0] lane_q, lane_d;
	logic              accept;
	logic              feature_ok;
	logic              lane_ok;
	logic              last;

	assign cmd.ready  = (state_q == ST_IDLE) && !busy;
	assign accept     = cmd.valid && cmd.ready;
	assign feature_ok = {1'b0, cmd.data.feature_index} < (FEAT_W + 1)'(FEATURES);
	assign lane_ok    = {1'b0, cmd.data.neuron_index} < (LANE_W + 1)'(NEURONS);
	assign last       = lane_q == LANE_W'(NEURONS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		feature_q <= feature_d;
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		feature_d   = feature_q;
		lane_d      = lane_q;
		issue.valid = 1'b0;
		issue.op    = op_q;
		issue.lane  = lane_q;
		issue.last  = last;
		wr.we_weight   = 1'b0;
		wr.we_bias     = 1'b0;
		wr.we_acc      = 1'b0;
		wr.weight_addr = {cmd.data.feature_index, cmd.data.neuron_index};
		wr.lane        = cmd.data.neuron_index;
		wr.weight      = cmd.data.weight_value;
		wr.word        = cmd.data.word_value;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					feature_d = cmd.data.feature_index;
					lane_d    = '0;
					unique case (cmd.data.operation)
						OP_LOAD_WEIGHT: begin
							wr.we_weight = feature_ok && lane_ok;
						end
						OP_LOAD_BIAS: begin
							wr.we_bias = lane_ok;
						end
						OP_SET_ENTRY: begin
							wr.we_acc = lane_ok;
						end
						OP_START_BIAS: begin
							op_d    = ROW_START;
							state_d = ST_RUN;
						end
						OP_ADD_FEATURE: begin
							op_d = ROW_ADD;
							if (feature_ok) begin
								state_d = ST_RUN;
							end
						end
						OP_REMOVE_FEATURE: begin
							op_d = ROW_SUB;
							if (feature_ok) begin
								state_d = ST_RUN;
							end
						end
						OP_READ_OUT: begin
							op_d    = ROW_READ;
							state_d = ST_RUN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RUN: begin
				if (!stall) begin
					issue.valid = 1'b1;
					lane_d      = lane_q + 1'b1;
					if (last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign weight_raddr = {feature_q, lane_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && issue.last |=> state_q == ST_IDLE)
		else $error("Sequencer did not return to idle after the final lane.");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.data.operation == OP_READ_OUT |=> state_q == ST_RUN && lane_q == '0)
		else $error("Read out did not start at lane zero.");

endmodule

### rtl/core/fau_lane_upd.sv
`timescale 1ns / 1ps

module fau_lane_upd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fau_pkg::issue_t             issue,
	input  fau_pkg::cmd_wr_t            wr,
	input  logic [fau_pkg::WGT_W-1:0]   weight_rdata,
	input  logic [fau_pkg::ACC_W-1:0]   acc_rdata,
	input  logic [fau_pkg::ACC_W-1:0]   bias_rdata,
	fau_res_if.source                   result,
	output logic                        acc_we,
	output logic [fau_pkg::LANE_W-1:0]  acc_waddr,
	output logic [fau_pkg::ACC_W-1:0]   acc_wdata,
	output logic                        stall,
	output logic                        busy
);
	import fau_pkg::*;

	logic              valid_s2;
	row_op_t           op_s2;
	logic [LANE_W-1:0] lane_s2;
	logic              last_s2;
	logic [NEURONS-1:0] bias_valid_q;
	logic [NEURONS-1:0] acc_valid_q;
	logic              out_valid_q;
	res_word_t         out_data_q;
	logic [ACC_W-1:0]  acc_cur;
	logic [ACC_W-1:0]  bias_cur;
	logic [ACC_W-1:0]  weight_ext;
	logic              emit;

	assign stall = valid_s2 && (op_s2 == ROW_READ) && out_valid_q && !result.ready;
	assign busy  = valid_s2;
	assign emit  = valid_s2 && (op_s2 == ROW_READ) && !stall;

	assign acc_cur    = acc_valid_q[lane_s2] ? acc_rdata : '0;
	assign bias_cur   = bias_valid_q[lane_s2] ? bias_rdata : '0;
	assign weight_ext = {{(ACC_W - WGT_W){weight_rdata[WGT_W-1]}}, weight_rdata};

	always_comb begin
		acc_we    = valid_s2 && (op_s2 != ROW_READ);
		acc_waddr = lane_s2;
		unique case (op_s2)
			ROW_START: acc_wdata = bias_cur;
			ROW_ADD:   acc_wdata = acc_cur + weight_ext;
			ROW_SUB:   acc_wdata = acc_cur - weight_ext;
			ROW_READ:  acc_wdata = acc_cur;
			default:   acc_wdata = acc_cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
			bias_valid_q <= '0;
			acc_valid_q  <= '0;
		end else begin
			if (!stall) begin
				valid_s2 <= issue.valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr.we_bias) begin
				bias_valid_q[wr.lane] <= 1'b1;
			end
			if (wr.we_acc) begin
				acc_valid_q[wr.lane] <= 1'b1;
			end
			if (acc_we) begin
				acc_valid_q[lane_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && issue.valid) begin
			op_s2   <= issue.op;
			lane_s2 <= issue.lane;
			last_s2 <= issue.last;
		end
		if (emit) begin
			out_data_q.lane_index        <= lane_s2;
			out_data_q.accumulator_value <= acc_cur;
			out_data_q.last_lane         <= last_s2;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_we && wr.we_acc))
		else $error("Accumulator written by a command and a lane update at once.");

	assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !issue.valid)
		else $error("Lane issued while the read out stage is stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.last_lane |-> result.data.lane_index == LANE_W'(NEURONS - 1))
		else $error("Last lane flag on a lane other than the final one.");

endmodule

### rtl/core/feature_accumulator_update.sv
`timescale 1ns / 1ps

// Feature accumulator update: first layer of an incrementally updated network.
// The cmd channel takes one command word per handshake: load a weight, load a
// bias entry, set an accumulator entry, restart the accumulator from the bias,
// add or remove a feature's weight row, or read out the accumulator.
// The result channel returns one word per lane on read out, lanes 0 to 63 in
// order, with last_lane set on lane 63. Sums wrap modulo 2^16.
// Load and set commands leave the sequencer idle, so cmd.ready stays high.
// Row commands and read out walk the 64 lanes one per cycle, unless the result
// channel stalls, through the accumulator memory's read and write ports, and
// cmd.ready returns once the last lane leaves the update stage. Read out words
// are registered. A stalled result channel holds the current word and pauses
// the lane walk without losing a lane; commands are not taken until the walk completes.
// Reset (arst_n low) clears the bias and accumulator to zero through per-lane
// valid bits, so no clearing pass is needed. The weight table is undefined
// until written.
module feature_accumulator_update (
	input  logic clk,
	input  logic arst_n,
	fau_cmd_if.sink   cmd,
	fau_res_if.source result
);
	import fau_pkg::*;

	issue_t             issue;
	cmd_wr_t            wr;
	logic [WADDR_W-1:0] weight_raddr;
	logic [WGT_W-1:0]   weight_rdata;
	logic [ACC_W-1:0]   acc_rdata;
	logic [ACC_W-1:0]   bias_rdata;
	logic               upd_we;
	logic [LANE_W-1:0]  upd_waddr;
	logic [ACC_W-1:0]   upd_wdata;
	logic               acc_we;
	logic [LANE_W-1:0]  acc_waddr;
	logic [ACC_W-1:0]   acc_wdata;
	logic               stall;
	logic               busy;

	fau_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stall        (stall),
		.busy         (busy),
		.issue        (issue),
		.wr           (wr),
		.weight_raddr (weight_raddr)
	);

	fau_ram #(.WIDTH(WGT_W), .DEPTH(FEATURES * NEURONS)) u_weight_ram (
		.clk   (clk),
		.we    (wr.we_weight),
		.waddr (wr.weight_addr),
		.wdata (wr.weight),
		.re    (issue.valid),
		.raddr (weight_raddr),
		.rdata (weight_rdata)
	);

	fau_ram #(.WIDTH(ACC_W), .DEPTH(NEURONS)) u_bias_ram (
		.clk   (clk),
		.we    (wr.we_bias),
		.waddr (wr.lane),
		.wdata (wr.word),
		.re    (issue.valid),
		.raddr (issue.lane),
		.rdata (bias_rdata)
	);

	assign acc_we    = upd_we || wr.we_acc;
	assign acc_waddr = upd_we ? upd_waddr : wr.lane;
	assign acc_wdata = upd_we ? upd_wdata : wr.word;

	fau_ram #(.WIDTH(ACC_W), .DEPTH(NEURONS)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (issue.valid),
		.raddr (issue.lane),
		.rdata (acc_rdata)
	);

	fau_lane_upd u_lane_upd (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue        (issue),
		.wr           (wr),
		.weight_rdata (weight_rdata),
		.acc_rdata    (acc_rdata),
		.bias_rdata   (bias_rdata),
		.result       (result),
		.acc_we       (upd_we),
		.acc_waddr    (upd_waddr),
		.acc_wdata    (upd_wdata),
		.stall        (stall),
		.busy         (busy)
	);

endmodule
